// ===== rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Shared widths and codes for the sorted key table: request kinds, the response
// word, search modes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int KEY_PORT_W = 64;
	localparam int START_W    = 8;
	localparam int END_W      = 9;
	localparam int POS_W      = 10;
	localparam int COUNT_W    = 9;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	localparam logic [2:0] MODE_EQ = 3'd0;
	localparam logic [2:0] MODE_LE = 3'd1;
	localparam logic [2:0] MODE_GE = 3'd2;
	localparam logic [2:0] MODE_LT = 3'd3;
	localparam logic [2:0] MODE_GT = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_MODE  = 2'd2;
	localparam logic [1:0] STATUS_RANGE = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [1:0]         status;
		logic [COUNT_W-1:0] entry_count;
	} rsp_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LAST,
		ST_PROBE_RD,
		ST_PROBE_CMP,
		ST_SHIFT_PRIME,
		ST_SHIFT,
		ST_PUT,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/skt_req_if.sv =====
// ----------------------------------------------------------------------------
// skt_req_if
// Request channel: one word is an insert or a search item.
// ----------------------------------------------------------------------------
interface skt_req_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [skt_pkg::KEY_PORT_W-1:0]      key;
	logic [2:0]                          mode;
	logic [skt_pkg::START_W-1:0]         range_start;
	logic signed [skt_pkg::END_W-1:0]    range_end;

	modport source (output valid, kind, key, mode, range_start, range_end, input ready);
	modport sink (input valid, kind, key, mode, range_start, range_end, output ready);
endinterface

// ===== rtl/skt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// skt_rsp_if
// Response channel: one word per request item.
// ----------------------------------------------------------------------------
interface skt_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [skt_pkg::POS_W-1:0]    position;
	logic [1:0]                          status;
	logic [skt_pkg::COUNT_W-1:0]         entry_count;

	modport source (output valid, position, status, entry_count, input ready);
	modport sink (input valid, position, status, entry_count, output ready);
endinterface

// ===== rtl/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram
// Key table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module skt_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/skt_seq.sv =====
// ----------------------------------------------------------------------------
// skt_seq
// Sequencer for the key table: range checks, binary search probes through
// one shared key compare, entry shifting and the ordered write.
// ----------------------------------------------------------------------------
module skt_seq #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_WIDTH = 64,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1),
	localparam int SW = ((CW > skt_pkg::END_W) ? CW : skt_pkg::END_W) + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	skt_req_if.sink             req,
	output logic [AW-1:0]       rd_addr,
	input  logic [KEY_WIDTH-1:0] rd_data,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [KEY_WIDTH-1:0] wr_data,
	output logic                res_valid,
	output skt_pkg::rsp_word_t  res_word,
	input  logic                res_ready
);

	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic signed [SW-1:0] ONE_S = SW'(1);
	localparam logic signed [SW-1:0] NEG_ONE_S = {SW{1'b1}};

	skt_pkg::state_t state_q, state_d;

	logic                  kind_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [2:0]            mode_q;
	logic signed [SW-1:0]  lo_q, hi_q, mid_q, pos_q;
	logic [1:0]            status_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         count_q;
	logic                  count_inc;

	logic signed [SW-1:0]  count_s, last_s, hi_res, idx_s, mid_w, miss_pos, hit_pos;
	logic signed [SW:0]    sum_w;
	logic [CW-1:0]         cnt_m1, idx_m2;
	logic [CW+skt_pkg::COUNT_W-1:0] cnt_ext;
	logic                  is_full, is_empty, key_eq, key_gt;

	assign count_s  = {{(SW-CW){1'b0}}, count_q};
	assign last_s   = count_s - ONE_S;
	assign hi_res   = (hi_q == NEG_ONE_S) ? last_s : hi_q;
	assign idx_s    = {{(SW-CW){1'b0}}, idx_q};
	assign sum_w    = {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
	assign mid_w    = sum_w[SW:1];
	assign cnt_m1   = count_q - 1'b1;
	assign idx_m2   = idx_q - CW'(2);
	assign cnt_ext  = {{skt_pkg::COUNT_W{1'b0}}, count_q};
	assign is_full  = (count_q >= DEPTH_C);
	assign is_empty = (count_q == '0);

	// shared key compare
	assign key_eq = (rd_data == key_q);
	assign key_gt = (rd_data > key_q);

	always_comb begin
		case (mode_q)
			skt_pkg::MODE_LE, skt_pkg::MODE_LT: miss_pos = hi_q;
			skt_pkg::MODE_GE, skt_pkg::MODE_GT: miss_pos = lo_q;
			default: miss_pos = NEG_ONE_S;
		endcase
	end

	always_comb begin
		case (mode_q)
			skt_pkg::MODE_LT: hit_pos = mid_q - ONE_S;
			skt_pkg::MODE_GT: hit_pos = mid_q + ONE_S;
			default: hit_pos = mid_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			skt_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = skt_pkg::ST_CHECK;
				end
			end
			skt_pkg::ST_CHECK: begin
				if (kind_q == skt_pkg::KIND_INSERT) begin
					if (is_full || is_empty) begin
						state_d = skt_pkg::ST_DONE;
					end else begin
						state_d = skt_pkg::ST_LAST;
					end
				end else if (mode_q > skt_pkg::MODE_GT || hi_res < lo_q ||
						hi_res >= count_s) begin
					state_d = skt_pkg::ST_DONE;
				end else begin
					state_d = skt_pkg::ST_PROBE_RD;
				end
			end
			skt_pkg::ST_LAST: begin
				state_d = key_gt ? skt_pkg::ST_PROBE_RD : skt_pkg::ST_DONE;
			end
			skt_pkg::ST_PROBE_RD: begin
				if (hi_q >= lo_q) begin
					state_d = skt_pkg::ST_PROBE_CMP;
				end else if (kind_q == skt_pkg::KIND_INSERT) begin
					state_d = skt_pkg::ST_SHIFT_PRIME;
				end else begin
					state_d = skt_pkg::ST_DONE;
				end
			end
			skt_pkg::ST_PROBE_CMP: begin
				if (!key_eq) begin
					state_d = skt_pkg::ST_PROBE_RD;
				end else if (kind_q == skt_pkg::KIND_INSERT) begin
					state_d = skt_pkg::ST_SHIFT_PRIME;
				end else begin
					state_d = skt_pkg::ST_DONE;
				end
			end
			skt_pkg::ST_SHIFT_PRIME: begin
				state_d = skt_pkg::ST_SHIFT;
			end
			skt_pkg::ST_SHIFT: begin
				if ((idx_s - ONE_S) == pos_q) begin
					state_d = skt_pkg::ST_PUT;
				end
			end
			skt_pkg::ST_PUT: begin
				state_d = skt_pkg::ST_DONE;
			end
			skt_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = skt_pkg::ST_IDLE;
				end
			end
			default: state_d = skt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		res_valid = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = key_q;
		count_inc = 1'b0;
		case (state_q)
			skt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			skt_pkg::ST_CHECK: begin
				rd_addr = cnt_m1[AW-1:0];
				if (kind_q == skt_pkg::KIND_INSERT && is_empty) begin
					wr_en     = 1'b1;
					count_inc = 1'b1;
				end
			end
			skt_pkg::ST_LAST: begin
				if (!key_gt) begin
					wr_en     = 1'b1;
					wr_addr   = count_q[AW-1:0];
					count_inc = 1'b1;
				end
			end
			skt_pkg::ST_PROBE_RD: begin
				rd_addr = mid_w[AW-1:0];
			end
			skt_pkg::ST_SHIFT_PRIME: begin
				rd_addr = cnt_m1[AW-1:0];
			end
			skt_pkg::ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_data;
				rd_addr = idx_m2[AW-1:0];
			end
			skt_pkg::ST_PUT: begin
				wr_en     = 1'b1;
				wr_addr   = pos_q[AW-1:0];
				count_inc = 1'b1;
			end
			skt_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (count_inc) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			skt_pkg::ST_IDLE: begin
				if (req.valid) begin
					kind_q   <= req.kind;
					key_q    <= req.key[KEY_WIDTH-1:0];
					mode_q   <= req.mode;
					lo_q     <= {{(SW-skt_pkg::START_W){1'b0}}, req.range_start};
					hi_q     <= {{(SW-skt_pkg::END_W){req.range_end[skt_pkg::END_W-1]}},
						req.range_end};
					pos_q    <= NEG_ONE_S;
					status_q <= skt_pkg::STATUS_OK;
				end
			end
			skt_pkg::ST_CHECK: begin
				if (kind_q == skt_pkg::KIND_INSERT) begin
					if (is_full) begin
						status_q <= skt_pkg::STATUS_FULL;
					end else if (is_empty) begin
						pos_q <= count_s;
					end
				end else if (mode_q > skt_pkg::MODE_GT) begin
					status_q <= skt_pkg::STATUS_MODE;
				end else if (hi_res < lo_q) begin
					pos_q <= NEG_ONE_S;
				end else if (hi_res >= count_s) begin
					status_q <= skt_pkg::STATUS_RANGE;
				end else begin
					hi_q <= hi_res;
				end
			end
			skt_pkg::ST_LAST: begin
				if (!key_gt) begin
					pos_q <= count_s;
				end else begin
					lo_q   <= '0;
					hi_q   <= last_s;
					mode_q <= skt_pkg::MODE_GE;
				end
			end
			skt_pkg::ST_PROBE_RD: begin
				if (hi_q >= lo_q) begin
					mid_q <= mid_w;
				end else begin
					pos_q <= miss_pos;
				end
			end
			skt_pkg::ST_PROBE_CMP: begin
				if (key_eq) begin
					pos_q <= hit_pos;
				end else if (key_gt) begin
					hi_q <= mid_q - ONE_S;
				end else begin
					lo_q <= mid_q + ONE_S;
				end
			end
			skt_pkg::ST_SHIFT_PRIME: begin
				idx_q <= count_q;
			end
			skt_pkg::ST_SHIFT: begin
				idx_q <= idx_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res_word.position    = pos_q[skt_pkg::POS_W-1:0];
	assign res_word.status      = status_q;
	assign res_word.entry_count = cnt_ext[skt_pkg::COUNT_W-1:0];

endmodule

// ===== rtl/sorted_key_table_search_insert_top.sv =====
// Sorted key table with ordered insert and ranged binary search. Each request
// word gives exactly one response word. The table is a single memory with one
// read and one write port, and that port pair sets the rate. An append checks
// the last entry and writes behind it (an empty table is written at once), a
// search runs a read and a compare per probe with an extra step on a miss (at
// most 9 probes over 256 entries), and an ordered insert probes for its place,
// then moves the entries above it up, one entry per cycle, and writes the key.
// The response word is presented in the same cycle as the block is ready for
// the next accept. The block takes one item at a time and accepts the next one
// while the last response still waits in the output register. Table entries
// are not cleared at reset and no clearing pass is run: only stored entries
// are ever used.
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_top
// Top level: request and response channels, key table memory, sequencer
// and response output register.
// ----------------------------------------------------------------------------
module sorted_key_table_search_insert_top #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_WIDTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	skt_req_if.sink  req,
	skt_rsp_if.source rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [AW-1:0]        rd_addr, wr_addr;
	logic [KEY_WIDTH-1:0] rd_data, wr_data;
	logic                 wr_en;
	logic                 res_valid, res_ready;
	skt_pkg::rsp_word_t   res_word, rsp_word_q;
	logic                 rsp_valid_q;

	skt_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (KEY_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	skt_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res_valid (res_valid),
		.res_word  (res_word),
		.res_ready (res_ready)
	);

	// response word register
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_word_q <= res_word;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.position    = rsp_word_q.position;
	assign rsp.status      = rsp_word_q.status;
	assign rsp.entry_count = rsp_word_q.entry_count;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req.ready)
		else $error("request ready while a result is pending");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> rsp.valid)
		else $error("finished result not presented");

	a_full_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == skt_pkg::STATUS_FULL ||
			rsp.status == skt_pkg::STATUS_MODE ||
			rsp.status == skt_pkg::STATUS_RANGE)) |-> (rsp.position == '1))
		else $error("error status with a position other than none");

endmodule
